@@ rtl/expiring_slot_pool_allocator_core_assert.svh @@
// Assertion macros for the expiring slot pool allocator.
`ifndef EXPIRING_SLOT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define EXPIRING_SLOT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define ESPA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define ESPA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ESPA_ASSERT(lbl, prop, msg)
`define ESPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/espa_pkg.sv @@
// Types and constants shared by the expiring slot pool allocator.
`default_nettype none
package espa_pkg;

   localparam int SLOT_COUNT = 32;
   localparam int TIME_BITS  = 32;
   localparam int IDX_BITS   = $clog2(SLOT_COUNT);
   localparam int CNT_BITS   = $clog2(SLOT_COUNT + 1);
   localparam int LIFE_BITS  = 16;
   localparam int TOTAL_BITS = 32;
   localparam logic [LIFE_BITS-1:0] MIN_LIFE_RESET = LIFE_BITS'(3);

   typedef enum logic {
      FUNC_TICK    = 1'b0,
      FUNC_ACQUIRE = 1'b1
   } espa_func_type;

   typedef struct packed {
      logic                 func;
      logic [LIFE_BITS-1:0] lifetime;
   } espa_req_type;

   typedef struct packed {
      logic                  granted;
      logic [4:0]            slot;
      logic                  recycled;
      logic [5:0]            active_count;
      logic [TOTAL_BITS-1:0] recycle_total;
      logic [TOTAL_BITS-1:0] grant_total;
   } espa_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FREE,
      ST_EVICT,
      ST_WRITE,
      ST_DONE
   } espa_state_type;

endpackage
`default_nettype wire

@@ rtl/expiring_slot_pool_allocator_core.sv @@
// Top level of the expiring slot pool allocator: sequencer, expiry memory and counters.
// A tick sweeps every slot, the sweep reading one expiry per cycle; a full-pool acquire scans
// every expiry for the earliest; a free-slot acquire walks the pointer to a free slot; a
// rejected acquire goes straight to the result beat. Throughput: one item at a time, the
// next accepted the cycle after the beat, as the receiver cannot stall.
// Reset is synchronous and clears control, active bits and counters, but not the expiry memory.
`default_nettype none
`include "expiring_slot_pool_allocator_core_assert.svh"
module expiring_slot_pool_allocator_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire espa_pkg::espa_req_type       req_item,
   output logic                              rsp_strobe,
   output espa_pkg::espa_rsp_type            rsp_item,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [espa_pkg::LIFE_BITS-1:0] csr_data
);
   import espa_pkg::*;

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   // Control and sequencing state.
   espa_state_type        state_ff, state_in;
   logic [LIFE_BITS-1:0]  life_ff, life_in;
   logic [LIFE_BITS-1:0]  min_life_ff, min_life_in;
   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic [IDX_BITS-1:0]   ptr_ff, ptr_in;
   logic [SLOT_COUNT-1:0] active_ff, active_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [TOTAL_BITS-1:0] evict_total_ff, evict_total_in;
   logic [TOTAL_BITS-1:0] grant_total_ff, grant_total_in;

   // Scan pipeline: step issues a read, chk marks the returning data in the cycle after.
   logic [CNT_BITS-1:0]   step_ff, step_in;
   logic                  chk_ff, chk_in;
   logic [IDX_BITS-1:0]   chk_idx_ff, chk_idx_in;
   logic [TIME_BITS-1:0]  best_ff, best_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic [IDX_BITS-1:0]   cand_ff, cand_in;
   logic [IDX_BITS-1:0]   sel_ff, sel_in;
   logic                  granted_ff, granted_in;
   logic                  recyc_ff, recyc_in;

   // Expiry memory, one synchronous read port and one write port.
   logic [TIME_BITS-1:0]  expiry_mem [SLOT_COUNT];
   logic [TIME_BITS-1:0]  rd_data_ff;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  wr_en;
   logic [TIME_BITS-1:0]  wr_data;

   logic                  accept;
   logic                  pool_full;
   logic                  scan_issue;
   logic                  scan_end;
   logic [LIFE_BITS-1:0]  grant_life;
   logic [TIME_BITS:0]    expiry_sum;
   logic [15:0]           slot_wide;
   logic [15:0]           count_wide;

   assign accept     = start && !busy;
   assign pool_full  = (cnt_ff == CNT_BITS'(SLOT_COUNT));
   assign scan_issue = (step_ff < CNT_BITS'(SLOT_COUNT));
   assign scan_end   = !scan_issue;
   assign rd_addr    = step_ff[IDX_BITS-1:0];
   assign csr_ready  = 1'b1;

   // The granted lifetime is never below the configured minimum, and the expiry saturates.
   assign grant_life = (life_ff > min_life_ff) ? life_ff : min_life_ff;
   assign expiry_sum = {1'b0, time_ff} + (TIME_BITS + 1)'(grant_life);
   assign wr_data    = expiry_sum[TIME_BITS] ? TIME_MAX : expiry_sum[TIME_BITS-1:0];
   assign wr_en      = (state_ff == ST_WRITE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.func == FUNC_TICK) begin
                  state_in = ST_SWEEP;
               end else if (req_item.lifetime == '0) begin
                  state_in = ST_DONE;
               end else if (pool_full) begin
                  state_in = ST_EVICT;
               end else begin
                  state_in = ST_FREE;
               end
            end
         end
         ST_SWEEP: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_EVICT: begin
            if (scan_end) begin
               state_in = ST_WRITE;
            end
         end
         ST_FREE: begin
            if (!active_ff[cand_ff]) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_DONE: rsp_strobe = 1'b1;
         default: begin
            busy       = 1'b1;
            rsp_strobe = 1'b0;
         end
      endcase
   end

   // Datapath.
   always_comb begin
      life_in        = life_ff;
      min_life_in    = min_life_ff;
      time_in        = time_ff;
      ptr_in         = ptr_ff;
      active_in      = active_ff;
      cnt_in         = cnt_ff;
      evict_total_in = evict_total_ff;
      grant_total_in = grant_total_ff;
      step_in        = step_ff;
      chk_in         = 1'b0;
      chk_idx_in     = chk_idx_ff;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      cand_in        = cand_ff;
      sel_in         = sel_ff;
      granted_in     = granted_ff;
      recyc_in       = recyc_ff;

      if (csr_valid && csr_ready) begin
         min_life_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               life_in    = req_item.lifetime;
               step_in    = '0;
               cand_in    = ptr_ff;
               sel_in     = '0;
               granted_in = 1'b0;
               recyc_in   = (req_item.func == FUNC_ACQUIRE) && (req_item.lifetime != '0)
                            && pool_full;
               if (req_item.func == FUNC_TICK) begin
                  time_in = (time_ff == TIME_MAX) ? time_ff : time_ff + TIME_BITS'(1);
               end
            end
         end
         ST_SWEEP: begin
            if (scan_issue) begin
               step_in    = step_ff + CNT_BITS'(1);
               chk_in     = 1'b1;
               chk_idx_in = rd_addr;
            end
            if (chk_ff && active_ff[chk_idx_ff] && (rd_data_ff <= time_ff)) begin
               active_in[chk_idx_ff] = 1'b0;
               cnt_in                = cnt_ff - CNT_BITS'(1);
            end
         end
         ST_EVICT: begin
            if (scan_issue) begin
               step_in    = step_ff + CNT_BITS'(1);
               chk_in     = 1'b1;
               chk_idx_in = rd_addr;
            end
            // A strict compare keeps the lowest index on equal expiries.
            if (chk_ff && ((chk_idx_ff == '0) || (rd_data_ff < best_ff))) begin
               best_in     = rd_data_ff;
               best_idx_in = chk_idx_ff;
            end
            if (scan_end) begin
               sel_in = best_idx_in;
            end
         end
         ST_FREE: begin
            if (!active_ff[cand_ff]) begin
               sel_in = cand_ff;
            end else if (cand_ff == IDX_BITS'(SLOT_COUNT - 1)) begin
               cand_in = '0;
            end else begin
               cand_in = cand_ff + IDX_BITS'(1);
            end
         end
         ST_WRITE: begin
            active_in[sel_ff] = 1'b1;
            granted_in        = 1'b1;
            if (!recyc_ff) begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end else if (!(&evict_total_ff)) begin
               evict_total_in = evict_total_ff + TOTAL_BITS'(1);
            end
            if (!(&grant_total_ff)) begin
               grant_total_in = grant_total_ff + TOTAL_BITS'(1);
            end
            ptr_in = (sel_ff == IDX_BITS'(SLOT_COUNT - 1)) ? '0 : sel_ff + IDX_BITS'(1);
         end
         default: begin
            chk_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         min_life_ff    <= MIN_LIFE_RESET;
         time_ff        <= '0;
         ptr_ff         <= '0;
         active_ff      <= '0;
         cnt_ff         <= '0;
         evict_total_ff <= '0;
         grant_total_ff <= '0;
         chk_ff         <= 1'b0;
      end else begin
         state_ff       <= state_in;
         min_life_ff    <= min_life_in;
         time_ff        <= time_in;
         ptr_ff         <= ptr_in;
         active_ff      <= active_in;
         cnt_ff         <= cnt_in;
         evict_total_ff <= evict_total_in;
         grant_total_ff <= grant_total_in;
         chk_ff         <= chk_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      life_ff     <= life_in;
      step_ff     <= step_in;
      chk_idx_ff  <= chk_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      cand_ff     <= cand_in;
      sel_ff      <= sel_in;
      granted_ff  <= granted_in;
      recyc_ff    <= recyc_in;
   end

   // Expiry memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         expiry_mem[sel_ff] <= wr_data;
      end
      rd_data_ff <= expiry_mem[rd_addr];
   end

   // Result beat. The slot and count are narrowed to the field widths of the result.
   assign slot_wide  = 16'(sel_ff);
   assign count_wide = 16'(cnt_ff);

   always_comb begin
      rsp_item.granted       = granted_ff;
      rsp_item.slot          = slot_wide[4:0];
      rsp_item.recycled      = recyc_ff && granted_ff;
      rsp_item.active_count  = count_wide[5:0];
      rsp_item.recycle_total = evict_total_ff;
      rsp_item.grant_total   = grant_total_ff;
   end

   `ESPA_ASSERT_ALWAYS(a_reset_idle, reset |=> (!busy && !rsp_strobe), "not idle after reset")
   `ESPA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
   `ESPA_ASSERT(a_single_beat, rsp_strobe |=> !rsp_strobe, "more than one result beat")
   `ESPA_ASSERT(a_free_slot, (wr_en && !recyc_ff) |-> !active_ff[sel_ff], "free slot in use")
   `ESPA_ASSERT(a_recycle_full, (wr_en && recyc_ff) |-> pool_full, "eviction while not full")
   `ESPA_ASSERT(a_count_match, !busy |-> ($countones(active_ff) == int'(cnt_ff)), "bad count")

endmodule
`default_nettype wire

@@ verif/expiring_slot_pool_allocator_core_tb.sv @@
// Self-checking testbench for the expiring slot pool allocator core.
`timescale 1ns / 100ps

module expiring_slot_pool_allocator_core_tb;

   import espa_pkg::*;

   // Tracks the pool as the block should hold it and keeps the answers still owed.
   class slot_pool_tracker;
      logic                  active    [SLOT_COUNT];
      logic [TIME_BITS-1:0]  expiry    [SLOT_COUNT];
      logic [IDX_BITS-1:0]   next_ptr;
      logic [TIME_BITS-1:0]  now_ticks;
      logic [TOTAL_BITS-1:0] evictions;
      logic [TOTAL_BITS-1:0] grants;
      logic [LIFE_BITS-1:0]  min_life;
      espa_rsp_type          owed_answers [$];
      int                    mismatches;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            active[i] = 1'b0;
            expiry[i] = '0;
         end
         next_ptr   = '0;
         now_ticks  = '0;
         evictions  = '0;
         grants     = '0;
         min_life   = MIN_LIFE_RESET;
         mismatches = 0;
      endfunction

      // Adds with saturation at the all-ones value of the time width.
      function logic [TIME_BITS-1:0] time_sum(logic [TIME_BITS-1:0] a,
                                              logic [TIME_BITS-1:0] b);
         logic [TIME_BITS:0] wide;
         wide = {1'b0, a} + {1'b0, b};
         return wide[TIME_BITS] ? '1 : wide[TIME_BITS-1:0];
      endfunction

      task report_mismatch(string what, longint unsigned got, longint unsigned want);
         mismatches++;
         $display("[%0t] mismatch on %0s: got %0d, expected %0d", $time, what, got, want);
      endtask

      // Works out the answer to one accepted request and queues it.
      function void note_request(espa_req_type req);
         espa_rsp_type          ans;
         logic                  found;
         logic [LIFE_BITS-1:0]  life;
         logic [TIME_BITS-1:0]  best;
         int                    cand;
         int                    count;
         ans   = '0;
         found = 1'b0;
         count = 0;
         if (req.func == FUNC_TICK) begin
            now_ticks = time_sum(now_ticks, TIME_BITS'(1));
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (active[i] && expiry[i] <= now_ticks) begin
                  active[i] = 1'b0;
                  expiry[i] = '0;
               end
            end
         end else if (req.lifetime != '0) begin
            for (int i = 0; i < SLOT_COUNT && !found; i++) begin
               cand = (int'(next_ptr) + i) % SLOT_COUNT;
               if (!active[cand]) begin
                  ans.slot = IDX_BITS'(cand);
                  found    = 1'b1;
               end
            end
            if (!found) begin
               // Pool full: evict the earliest expiry, lowest index on a tie.
               best     = expiry[0];
               ans.slot = '0;
               for (int i = 1; i < SLOT_COUNT; i++) begin
                  if (expiry[i] < best) begin
                     best     = expiry[i];
                     ans.slot = IDX_BITS'(i);
                  end
               end
               ans.recycled = 1'b1;
               if (evictions != '1) evictions++;
            end
            next_ptr             = ans.slot + 1'b1;
            life                 = (req.lifetime > min_life) ? req.lifetime : min_life;
            active[ans.slot]     = 1'b1;
            expiry[ans.slot]     = time_sum(now_ticks, TIME_BITS'(life));
            if (grants != '1) grants++;
            ans.granted = 1'b1;
         end
         for (int i = 0; i < SLOT_COUNT; i++) count += active[i];
         ans.active_count  = CNT_BITS'(count);
         ans.recycle_total = evictions;
         ans.grant_total   = grants;
         owed_answers.push_back(ans);
      endfunction

      // Compares one result beat with the oldest answer owed.
      task check_response(espa_rsp_type got);
         espa_rsp_type want;
         if (owed_answers.size() == 0) begin
            report_mismatch("unexpected result beat", got.grant_total, 0);
         end else begin
            want = owed_answers.pop_front();
            if (got.granted !== want.granted)
               report_mismatch("granted", got.granted, want.granted);
            if (got.slot !== want.slot)
               report_mismatch("slot", got.slot, want.slot);
            if (got.recycled !== want.recycled)
               report_mismatch("recycled", got.recycled, want.recycled);
            if (got.active_count !== want.active_count)
               report_mismatch("active_count", got.active_count, want.active_count);
            if (got.recycle_total !== want.recycle_total)
               report_mismatch("recycle_total", got.recycle_total, want.recycle_total);
            if (got.grant_total !== want.grant_total)
               report_mismatch("grant_total", got.grant_total, want.grant_total);
         end
      endtask
   endclass

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int PHASE_COUNT  = 6;
   localparam int SETTLE_CYCLES = 40;

   // Kinds of random run: a mixed run, a burst of acquires that fills the pool,
   // and a burst of ticks that lets slots expire.
   typedef enum int {
      RUN_MIXED,
      RUN_ACQUIRE,
      RUN_TICK
   } run_kind_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   espa_req_type         req_item;
   logic                 rsp_strobe;
   espa_rsp_type         rsp_item;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [LIFE_BITS-1:0] csr_data;

   slot_pool_tracker tracker;
   int               cycle_count;

   expiring_slot_pool_allocator_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Every handshake is sampled at the rising edge, before any of the
   // non-blocking updates made at that edge have landed. A result beat always
   // belongs to an earlier request, so it is checked before a new request is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            tracker.check_response(rsp_item);
         if (start && !busy)
            tracker.note_request(req_item);
         if (csr_valid && csr_ready)
            tracker.min_life = csr_data;
      end
   end

   // Watchdog: ends the run if the block stops answering.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic espa_req_type make_req(espa_func_type f, logic [LIFE_BITS-1:0] life);
      espa_req_type r;
      r.func     = f;
      r.lifetime = life;
      return r;
   endfunction

   // Lifetimes lean towards small values so that slots expire within the run,
   // with zero, full-range and near-maximum values mixed in.
   function automatic logic [LIFE_BITS-1:0] pick_lifetime();
      int w;
      w = $urandom_range(0, 99);
      if (w < 6)       return '0;
      else if (w < 55) return LIFE_BITS'($urandom_range(1, 10));
      else if (w < 75) return LIFE_BITS'($urandom_range(1, 200));
      else if (w < 92) return LIFE_BITS'($urandom);
      else             return 16'hFFFF - LIFE_BITS'($urandom_range(0, 3));
   endfunction

   // Offers one request beat, first idling for a while at the given odds, and
   // returns at the edge at which the block took it. Start stays high afterwards,
   // so that back-to-back requests need only one assignment per edge.
   task automatic send_request(input espa_req_type item, input int idle_pct);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Holds requests off until every owed answer has arrived and the block has settled.
   // The first edge lets the request taken at the current edge be noted.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.owed_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_min_lifetime(input logic [LIFE_BITS-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      run_kind_type         kind;
      int                   run_left;
      int                   acquire_pct;
      int                   idle_pct;
      logic [LIFE_BITS-1:0] setting;
      espa_rsp_type         leftover;
      tracker   = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset minimum lifetime of three ticks.
      send_request(make_req(FUNC_TICK,    16'h0000), 19);  // sweep of an empty pool
      send_request(make_req(FUNC_ACQUIRE, 16'h0000), 19);  // zero lifetime is rejected
      send_request(make_req(FUNC_ACQUIRE, 16'h0001), 19);  // raised to the minimum
      send_request(make_req(FUNC_ACQUIRE, 16'hFFFF), 19);  // longest lifetime
      send_request(make_req(FUNC_ACQUIRE, 16'h0003), 19);  // exactly the minimum
      send_request(make_req(FUNC_ACQUIRE, 16'h0004), 19);
      repeat (4) send_request(make_req(FUNC_TICK, 16'h0000), 19);  // slots expire
      send_request(make_req(FUNC_ACQUIRE, 16'h0002), 19);  // pointer does not go back
      send_request(make_req(FUNC_ACQUIRE, 16'h8000), 19);
      send_request(make_req(FUNC_ACQUIRE, 16'h0000), 19);  // rejection with slots in use
      send_request(make_req(FUNC_ACQUIRE, 16'h5555), 19);
      send_request(make_req(FUNC_TICK,    16'hFFFF), 19);  // lifetime ignored on a tick
      send_request(make_req(FUNC_TICK,    16'hAAAA), 19);

      // Random part: one phase per minimum lifetime setting, the extremes included.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: setting = 16'h0000;
            1: setting = 16'hFFFF;
            2: setting = 16'h0001;
            3: setting = LIFE_BITS'($urandom);
            4: setting = MIN_LIFE_RESET;
            default: setting = LIFE_BITS'($urandom_range(0, 20));
         endcase
         write_min_lifetime(setting);
         // The third phase runs with no idling at all.
         idle_pct = (phase == 2) ? 0 : 19;
         run_left = 0;
         kind     = RUN_MIXED;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (run_left == 0) begin
               run_left = $urandom_range(8, 40);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: kind = RUN_MIXED;
                  4, 5, 6:    kind = RUN_ACQUIRE;
                  default:    kind = RUN_TICK;
               endcase
            end
            run_left--;
            case (kind)
               RUN_MIXED:   acquire_pct = 55;
               RUN_ACQUIRE: acquire_pct = 92;
               default:     acquire_pct = 15;
            endcase
            if (phase == 3 && n == ITEMS_PER_PHASE / 2)
               drain_results();
            send_request(make_req(($urandom_range(0, 99) < acquire_pct) ? FUNC_ACQUIRE
                                                                         : FUNC_TICK,
                                  pick_lifetime()), idle_pct);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (tracker.owed_answers.size() != 0) begin
         leftover = tracker.owed_answers.pop_front();
         tracker.report_mismatch("answer never delivered, slot", leftover.slot, 0);
      end
      if (tracker.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
